// ----- hw/rtl/mart_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mart_pkg
// Shared types and constants of the masked address rule table.
// ----------------------------------------------------------------------------
package mart_pkg;

  localparam int TableDepth = 64;
  localparam int CntW       = $clog2(TableDepth + 1);

  localparam int KeyW  = 32;
  localparam int AddrW = 32;
  localparam int KindW = 4;

  typedef enum logic [1:0] {
    CMD_SEARCH = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_NONE     = 3'd0,
    STAT_HIT      = 3'd1,
    STAT_UPDATED  = 3'd2,
    STAT_INSERTED = 3'd3,
    STAT_FULL     = 3'd4
  } stat_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_RES  = 3'b100
  } fsm_e;

  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [AddrW-1:0] addr;
    logic [AddrW-1:0] mask;
    logic [KindW-1:0] kinds;
  } entry_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [KeyW-1:0]  key;
    logic [AddrW-1:0] addr;
    logic [AddrW-1:0] mask;
    logic [KindW-1:0] kinds;
    logic [KindW-1:0] filter;
  } item_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic cmp;    // capture match flag
    logic load;   // write the new entry
    logic shift;  // take the neighbor's entry
  } cell_ctl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/mart_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mart_cell
// One table slot: holds an entry, compares it against the current word and
// takes the upper neighbor's entry when the table closes a gap.
// ----------------------------------------------------------------------------
module mart_cell (
  input  logic                clk_i,
  input  mart_pkg::cell_ctl_t ctl_i,
  input  logic                occupied_i,
  input  mart_pkg::item_t     item_i,
  input  mart_pkg::entry_t    next_i,
  output mart_pkg::entry_t    entry_o,
  output logic                match_o
);
  import mart_pkg::*;

  entry_t ent_q, ent_d;
  logic   match_q, match_d;

  always_comb begin
    case (item_i.command)
      CMD_SEARCH: begin
        match_d = occupied_i
                  && (((ent_q.addr ^ item_i.addr) & ent_q.mask) == '0)
                  && ((ent_q.kinds & item_i.filter) != '0);
      end
      CMD_UPDATE, CMD_REMOVE: begin
        match_d = occupied_i && (ent_q.key == item_i.key);
      end
      default: begin
        match_d = 1'b0;
      end
    endcase
  end

  always_comb begin
    ent_d = ent_q;
    if (ctl_i.load) begin
      ent_d.key   = item_i.key;
      ent_d.addr  = item_i.addr;
      ent_d.mask  = item_i.mask;
      ent_d.kinds = item_i.kinds;
    end else if (ctl_i.shift) begin
      ent_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    if (ctl_i.cmp) begin
      match_q <= match_d;
    end
  end

  assign entry_o = ent_q;
  assign match_o = match_q;

endmodule
`default_nettype wire

// ----- hw/rtl/masked_address_rule_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// masked_address_rule_table
// Ordered rule table built as a row of slot cells. Search by masked address;
// update/insert, remove by key; remove shifts upper cells down to keep order.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake          | word
//   --------+-----------+--------------------+-----------------------------------
//   in      | input     | in_valid_i/_stall_o| command, key, addr, mask, kinds,
//           |           |                    | filter
//   out     | output    | out_valid_o/_stall_i| status, hit key/addr/mask/kinds
//
// Sequence: a compare state captures every cell's match flag, then a resolve
// state resolves the first match, updates the cells and loads the result.
// A new word is taken in the resolve cycle, as the last word commits.
// Reset clears the fill count and the sequencer; slots hold no reset value.
// A stalled result holds the block in the resolve cycle until it can be
// replaced; a waiting stalled result also stalls input there, not in idle.
// ----------------------------------------------------------------------------
module masked_address_rule_table (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 command_i,
  input  logic [mart_pkg::KeyW-1:0]  entry_key_i,
  input  logic [mart_pkg::AddrW-1:0] query_addr_i,
  input  logic [mart_pkg::AddrW-1:0] addr_mask_i,
  input  logic [mart_pkg::KindW-1:0] kind_bits_i,
  input  logic [mart_pkg::KindW-1:0] kind_filter_i,
  // output channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [2:0]                 status_o,
  output logic [mart_pkg::KeyW-1:0]  hit_key_o,
  output logic [mart_pkg::AddrW-1:0] hit_addr_o,
  output logic [mart_pkg::AddrW-1:0] hit_mask_o,
  output logic [mart_pkg::KindW-1:0] hit_kinds_o
);
  import mart_pkg::*;

  localparam int EntW = $bits(entry_t);

  // sequencer
  fsm_e state_q, state_d;
  logic in_accept;
  logic out_free;
  logic commit;

  // captured word and fill count
  item_t           item_q;
  logic [CntW-1:0] count_q, count_d;

  // cell row
  entry_t          ent   [TableDepth];
  logic [TableDepth-1:0] match;
  logic [TableDepth-1:0] after;   // at or above the first match
  logic [TableDepth-1:0] first;   // one-hot first match
  logic [TableDepth-1:0] ins_sel; // append slot
  logic [TableDepth-1:0] load_v;
  logic [TableDepth-1:0] shift_v;
  logic                  any_hit;
  entry_t                sel_ent;
  entry_t                new_ent;

  // result
  stat_e  res_stat;
  entry_t res_ent;
  logic   out_valid_q;
  stat_e  out_stat_q;
  entry_t out_ent_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) || ((state_q == S_RES) && out_free));
  assign in_accept  = in_valid_i && !in_stall_o;
  assign commit     = (state_q == S_RES) && out_free;

  always_comb begin
    case (state_q)
      S_IDLE:  state_d = in_accept ? S_CMP : S_IDLE;
      S_CMP:   state_d = S_RES;
      S_RES: begin
        if (out_free) begin
          state_d = in_accept ? S_CMP : S_IDLE;
        end else begin
          state_d = S_RES;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.command <= command_i;
      item_q.key     <= entry_key_i;
      item_q.addr    <= query_addr_i;
      item_q.mask    <= addr_mask_i;
      item_q.kinds   <= kind_bits_i;
      item_q.filter  <= kind_filter_i;
    end
  end

  // cells; each one hands its entry to the cell below on a remove
  for (genvar i = 0; i < TableDepth; i++) begin : g_cell
    cell_ctl_t ctl;
    entry_t    nxt;

    assign ctl.cmp   = (state_q == S_CMP);
    assign ctl.load  = commit && load_v[i];
    assign ctl.shift = commit && shift_v[i];

    if (i == TableDepth - 1) begin : g_top
      assign nxt = ent[i];
    end else begin : g_mid
      assign nxt = ent[i+1];
    end

    mart_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .occupied_i (CntW'(i) < count_q),
      .item_i     (item_q),
      .next_i     (nxt),
      .entry_o    (ent[i]),
      .match_o    (match[i])
    );

    assign after[i]   = |match[i:0];
    assign ins_sel[i] = (CntW'(i) == count_q);

    if (i == 0) begin : g_first0
      assign first[i] = match[i];
    end else begin : g_firstn
      assign first[i] = match[i] && !after[i-1];
    end
  end

  assign any_hit = after[TableDepth-1];

  // AND-OR select of the first matching entry
  always_comb begin
    logic [EntW-1:0] acc;
    acc = '0;
    for (int i = 0; i < TableDepth; i++) begin
      acc = acc | (ent[i] & {EntW{first[i]}});
    end
    sel_ent = entry_t'(acc);
  end

  assign new_ent.key   = item_q.key;
  assign new_ent.addr  = item_q.addr;
  assign new_ent.mask  = item_q.mask;
  assign new_ent.kinds = item_q.kinds;

  always_comb begin
    res_stat = STAT_NONE;
    res_ent  = '0;
    load_v   = '0;
    shift_v  = '0;
    count_d  = count_q;
    case (item_q.command)
      CMD_SEARCH: begin
        if (any_hit) begin
          res_stat = STAT_HIT;
          res_ent  = sel_ent;
        end
      end
      CMD_UPDATE: begin
        if (any_hit) begin
          res_stat = STAT_UPDATED;
          res_ent  = new_ent;
          load_v   = first;
        end else if (count_q < CntW'(TableDepth)) begin
          res_stat = STAT_INSERTED;
          res_ent  = new_ent;
          load_v   = ins_sel;
          count_d  = count_q + CntW'(1);
        end else begin
          res_stat = STAT_FULL;
        end
      end
      CMD_REMOVE: begin
        if (any_hit) begin
          res_stat = STAT_HIT;
          res_ent  = sel_ent;
          shift_v  = after;
          count_d  = count_q - CntW'(1);
        end
      end
      default: begin
        res_stat = STAT_NONE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_stat_q <= res_stat;
      out_ent_q  <= res_ent;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_stat_q;
  assign hit_key_o   = out_ent_q.key;
  assign hit_addr_o  = out_ent_q.addr;
  assign hit_mask_o  = out_ent_q.mask;
  assign hit_kinds_o = out_ent_q.kinds;

endmodule
`default_nettype wire
